/* rtl/core/assert_macros.svh */
// assertion helpers for the checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define LFPS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("lfps assertion failed");

// antecedent implies consequent on the next edge
`define LFPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("lfps assertion failed");

`endif

/* rtl/core/lfps_pkg.sv */
`timescale 1ns / 1ps
package lfps_pkg;

	localparam int HISTORY_DEPTH = 16;
	localparam int SENSOR_COUNT  = 8;

	localparam int IDX_W   = $clog2(HISTORY_DEPTH);
	localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int DIR_W   = 7;
	localparam int ACC_W   = DIR_W + CNT_W;
	localparam int GAIN_W  = 4;
	localparam int GSUM_W  = GAIN_W + 2;
	localparam int PROD_W  = GAIN_W + 1 + DIR_W;
	localparam int MAC_W   = PROD_W + 2;
	localparam int MAG_W   = ((ACC_W > MAC_W) ? ACC_W : MAC_W) - 1;
	localparam int SN_W    = MAG_W + 1;
	localparam int DIV_W   = (CNT_W > GSUM_W) ? CNT_W : GSUM_W;
	localparam int DSTEP_W = $clog2(MAG_W);
	localparam int SPEED_W = 8;
	localparam int CLAMP_W = 6;
	localparam int SPX_W   = 10;

	localparam int SUM_LIMIT  = 16;
	localparam int BASE_SPEED = 100;
	localparam int SPEED_STEP = 5;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_COMMIT_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P          = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D          = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I          = 2'd3;

	localparam logic [GAIN_W-1:0] COMMIT_INTERVAL_RST = 4'd5;
	localparam logic [GAIN_W-1:0] GAIN_P_RST          = 4'd8;
	localparam logic [GAIN_W-1:0] GAIN_D_RST          = 4'd2;
	localparam logic [GAIN_W-1:0] GAIN_I_RST          = 4'd2;

	typedef logic [SENSOR_COUNT-1:0] pattern_t;
	typedef logic signed [DIR_W-1:0] dir_t;

	localparam logic signed [DIR_W-1:0] BIT_WEIGHT [SENSOR_COUNT] = '{
		-7'sd16, -7'sd14, -7'sd12, 7'sd4, 7'sd4, 7'sd12, 7'sd14, 7'sd16
	};

	function automatic dir_t pattern_dir(input pattern_t pat);
		dir_t acc;
		acc = '0;
		for (int b = 0; b < SENSOR_COUNT; b++) begin
			if (pat[b]) begin
				acc = acc + BIT_WEIGHT[b];
			end
		end
		return acc;
	endfunction

endpackage

/* rtl/core/line_follow_pid_steering.sv */
`timescale 1ns / 1ps
// a committing word runs a 16-slot history walk, two 13-step restoring divides on one
// shared divider and a multiply-accumulate of the P, D and I terms before its result,
// and the second divide is skipped when the gain total is zero
// throughput: one word per cycle when it does not commit; a committing word holds
// in_stall until its result is loaded, which waits while the output is stalled
// arst_n clears history valid bits, slot index, reading count, sequencer and output
// valid, and loads the default config (interval 5, gains 8/2/2)
module line_follow_pid_steering (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lfps_pkg::SENSOR_COUNT-1:0] line_pattern,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lfps_pkg::SPEED_W-1:0]      left_speed,
	output logic [lfps_pkg::SPEED_W-1:0]      right_speed,
	output logic                              line_seen,
	output logic signed [lfps_pkg::DIR_W-1:0] prop_term,
	output logic signed [lfps_pkg::DIR_W-1:0] deriv_term,
	output logic signed [lfps_pkg::DIR_W-1:0] integ_term,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lfps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfps_pkg::GAIN_W-1:0]       cfg_data
);
	import lfps_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_ILD  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_MAC  = 3'd4;
	localparam logic [2:0] S_SLD  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);
	localparam logic [DSTEP_W-1:0] LAST_STEP = DSTEP_W'(MAG_W - 1);

	logic [2:0]           state_q;
	logic [GAIN_W-1:0]    ci_q, gp_q, gd_q, gi_q;
	logic [GAIN_W-1:0]    rc_q;
	logic [IDX_W-1:0]     slot_q;
	logic [IDX_W-1:0]     k_q;
	logic [HISTORY_DEPTH-1:0] valid_q;
	pattern_t             hist_q [HISTORY_DEPTH];
	logic signed [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 seen_q;
	dir_t                 p_q, pd_q, integ_q;
	logic                 cur_empty_q;
	logic [1:0]           mstep_q;
	logic signed [MAC_W-1:0] mac_q;
	logic                 div_sel_q;
	logic                 gzero_q;
	logic [MAG_W-1:0]     quo_q;
	logic [DIV_W-1:0]     rem_q, div_q;
	logic                 neg_q;
	logic [DSTEP_W-1:0]   dstep_q;

	logic                 accept, commit, fin_load;
	logic [GAIN_W-1:0]    rc_inc;
	logic [IDX_W-1:0]     slot_inc, prev_idx;
	pattern_t             rd_pat;
	dir_t                 rd_dir, d_val;
	logic signed [DIR_W:0] diff;
	logic [GSUM_W-1:0]    gsum;
	logic                 div_load;
	logic signed [SN_W-1:0] div_num, num_abs, div_res;
	logic [DIV_W-1:0]     div_den;
	logic [DIV_W:0]       rem_sh, rem_sub;
	logic                 ge;
	logic [GAIN_W-1:0]    mac_gain;
	dir_t                 mac_op;
	logic signed [PROD_W-1:0] prod;
	logic signed [SN_W-1:0] sum_full;
	logic signed [CLAMP_W-1:0] sum_c;
	logic signed [SPX_W-1:0] corr, left_x, right_x;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign rc_inc    = rc_q + 1'b1;
	assign commit    = !(rc_inc < ci_q);
	assign slot_inc  = (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
	assign prev_idx  = (slot_q == '0) ? LAST_IDX : slot_q - 1'b1;
	assign rd_pat    = valid_q[k_q] ? hist_q[k_q] : '0;
	assign rd_dir    = pattern_dir(rd_pat);
	assign gsum      = GSUM_W'(gp_q) + GSUM_W'(gd_q) + GSUM_W'(gi_q);

	// half the change, toward zero
	assign diff  = (DIR_W + 1)'(p_q) - (DIR_W + 1)'(pd_q);
	assign d_val = DIR_W'((diff + (DIR_W + 1)'(diff[DIR_W])) >>> 1);

	// shared divider operands
	always_comb begin
		div_load = 1'b0;
		div_num  = SN_W'(acc_q);
		div_den  = DIV_W'(cnt_q);
		if (state_q == S_ILD) begin
			div_load = 1'b1;
		end else if (state_q == S_SLD && gsum != '0) begin
			div_load = 1'b1;
			div_num  = SN_W'(mac_q);
			div_den  = DIV_W'(gsum);
		end
	end
	assign num_abs = div_num[SN_W-1] ? -div_num : div_num;
	assign rem_sh  = {rem_q, quo_q[MAG_W-1]};
	assign ge      = (rem_sh >= {1'b0, div_q});
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign div_res = neg_q ? -SN_W'(quo_q) : SN_W'(quo_q);

	always_comb begin
		case (mstep_q)
			2'd0: begin
				mac_gain = gp_q;
				mac_op   = p_q;
			end
			2'd1: begin
				mac_gain = gd_q;
				mac_op   = d_val;
			end
			default: begin
				mac_gain = gi_q;
				mac_op   = integ_q;
			end
		endcase
	end
	assign prod = $signed({1'b0, mac_gain}) * mac_op;

	// clamp and wheel speeds
	assign sum_full = gzero_q ? '0 : div_res;
	always_comb begin
		if (sum_full > SN_W'(SUM_LIMIT)) begin
			sum_c = CLAMP_W'(SUM_LIMIT);
		end else if (sum_full < -SN_W'(SUM_LIMIT)) begin
			sum_c = -CLAMP_W'(SUM_LIMIT);
		end else begin
			sum_c = CLAMP_W'(sum_full);
		end
	end
	assign corr     = SPX_W'(sum_c) * SPX_W'(SPEED_STEP);
	assign left_x   = SPX_W'(BASE_SPEED) + corr;
	assign right_x  = SPX_W'(BASE_SPEED) - corr;
	assign fin_load = (state_q == S_FIN) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= COMMIT_INTERVAL_RST;
			gp_q <= GAIN_P_RST;
			gd_q <= GAIN_D_RST;
			gi_q <= GAIN_I_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COMMIT_INTERVAL: ci_q <= cfg_data;
				REG_GAIN_P:          gp_q <= cfg_data;
				REG_GAIN_D:          gd_q <= cfg_data;
				REG_GAIN_I:          gi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && commit) begin
			hist_q[slot_inc] <= line_pattern;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rc_q      <= '0;
			slot_q    <= '0;
			valid_q   <= '0;
			k_q       <= '0;
			mstep_q   <= '0;
			dstep_q   <= '0;
			div_sel_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (commit) begin
							rc_q              <= '0;
							slot_q            <= slot_inc;
							valid_q[slot_inc] <= 1'b1;
							k_q               <= '0;
							state_q           <= S_WALK;
						end else begin
							rc_q <= rc_inc;
						end
					end
				end
				S_WALK: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_IDX) begin
						state_q <= S_ILD;
					end
				end
				S_ILD: begin
					div_sel_q <= 1'b0;
					dstep_q   <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					dstep_q <= dstep_q + 1'b1;
					if (dstep_q == LAST_STEP) begin
						mstep_q <= '0;
						state_q <= div_sel_q ? S_FIN : S_MAC;
					end
				end
				S_MAC: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 2'd2) begin
						state_q <= S_SLD;
					end
				end
				S_SLD: begin
					div_sel_q <= 1'b1;
					dstep_q   <= '0;
					state_q   <= (gsum == '0) ? S_FIN : S_DIV;
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept && commit) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			seen_q      <= 1'b0;
			cur_empty_q <= (line_pattern == '0);
		end
		if (state_q == S_WALK) begin
			if (valid_q[k_q]) begin
				acc_q <= acc_q + ACC_W'(rd_dir);
				cnt_q <= cnt_q + 1'b1;
			end
			seen_q <= seen_q || (rd_pat != '0);
			if (k_q == slot_q) begin
				p_q <= rd_dir;
			end
			if (k_q == prev_idx) begin
				pd_q <= rd_dir;
			end
		end
		if (state_q == S_ILD) begin
			mac_q <= '0;
		end
		if (state_q == S_MAC) begin
			if (mstep_q == 2'd0) begin
				integ_q <= DIR_W'(div_res);
			end
			mac_q <= mac_q + MAC_W'(prod);
		end
		if (state_q == S_SLD) begin
			gzero_q <= (gsum == '0);
		end
		if (div_load) begin
			neg_q <= div_num[SN_W-1];
			quo_q <= num_abs[MAG_W-1:0];
			rem_q <= '0;
			div_q <= div_den;
		end else if (state_q == S_DIV) begin
			rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fin_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			left_speed  <= cur_empty_q ? '0 : left_x[SPEED_W-1:0];
			right_speed <= cur_empty_q ? '0 : right_x[SPEED_W-1:0];
			line_seen   <= seen_q;
			prop_term   <= p_q;
			deriv_term  <= d_val;
			integ_term  <= integ_q;
		end
	end

endmodule

/* rtl/core/lfps_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lfps_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [lfps_pkg::SPEED_W-1:0]      left_speed,
	input logic [lfps_pkg::SPEED_W-1:0]      right_speed,
	input logic                              line_seen
);
	import lfps_pkg::*;

	localparam logic [SPEED_W:0] SPEED_TOTAL = (SPEED_W + 1)'(2 * BASE_SPEED);
	localparam logic [SPEED_W-1:0] SPEED_MAX =
		SPEED_W'(BASE_SPEED + SPEED_STEP * SUM_LIMIT);

	logic [SPEED_W:0] speed_sum;
	logic             speed_off;
	assign speed_sum = {1'b0, left_speed} + {1'b0, right_speed};
	assign speed_off = (left_speed == '0) && (right_speed == '0);

	`LFPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`LFPS_ASSERT(a_speed_pair, !out_valid || speed_sum == SPEED_TOTAL || speed_off)
	`LFPS_ASSERT(a_speed_max, !out_valid || (left_speed <= SPEED_MAX && right_speed <= SPEED_MAX))
	`LFPS_ASSERT(a_seen_drive, !out_valid || left_speed == '0 || line_seen)

endmodule

bind line_follow_pid_steering lfps_checker u_lfps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.left_speed  (left_speed),
	.right_speed (right_speed),
	.line_seen   (line_seen)
);

/* sim/line_follow_pid_steering_test.sv */
`timescale 1ns / 1ps
module line_follow_pid_steering_test;
	import lfps_pkg::*;

	typedef struct {
		logic [SPEED_W-1:0] left_speed;
		logic [SPEED_W-1:0] right_speed;
		logic               line_seen;
		dir_t               prop_term;
		dir_t               deriv_term;
		dir_t               integ_term;
	} steer_t;

	localparam int SENSOR_WEIGHT [SENSOR_COUNT] = '{-16, -14, -12, 4, 4, 12, 14, 16};
	localparam int SETTLE_CYCLES = 80;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	pattern_t                 line_pattern = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [SPEED_W-1:0]       left_speed;
	logic [SPEED_W-1:0]       right_speed;
	logic                     line_seen;
	dir_t                     prop_term;
	dir_t                     deriv_term;
	dir_t                     integ_term;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_COMMIT_INTERVAL;
	logic [GAIN_W-1:0]        cfg_data = '0;

	pattern_t pattern_q [$];
	steer_t   steer_expect_q [$];
	int       err_count = 0;
	int       send_idle = 0;
	int       recv_idle = 0;
	bit       pressure_go = 0;
	logic     long_hold = 1'b0;

	// steering model state
	pattern_t           hist_pat [HISTORY_DEPTH];
	bit                 hist_ok [HISTORY_DEPTH];
	logic [IDX_W-1:0]   slot = '0;
	logic [GAIN_W-1:0]  readings = '0;
	logic [GAIN_W-1:0]  commit_every = COMMIT_INTERVAL_RST;
	logic [GAIN_W-1:0]  weight_p = GAIN_P_RST;
	logic [GAIN_W-1:0]  weight_d = GAIN_D_RST;
	logic [GAIN_W-1:0]  weight_i = GAIN_I_RST;

	line_follow_pid_steering u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.line_pattern(line_pattern),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_speed(left_speed),
		.right_speed(right_speed),
		.line_seen(line_seen),
		.prop_term(prop_term),
		.deriv_term(deriv_term),
		.integ_term(integ_term),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int heading(pattern_t pat);
		int acc;
		acc = 0;
		for (int b = 0; b < SENSOR_COUNT; b++) begin
			if (pat[b]) begin
				acc += SENSOR_WEIGHT[b];
			end
		end
		return acc;
	endfunction

	function automatic void take_reading(pattern_t pat);
		steer_t   r;
		int       p, d, mean, acc, cnt, gsum, sum;
		int       prev_slot;
		pattern_t seen;
		readings = readings + 1'b1;
		if (readings < commit_every) begin
			return;
		end
		readings = '0;
		slot = slot + 1'b1;
		hist_ok[slot] = 1'b1;
		hist_pat[slot] = pat;
		prev_slot = (int'(slot) + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
		p = heading(pat);
		d = (p - heading(hist_pat[prev_slot])) / 2;
		acc = 0;
		cnt = 0;
		seen = '0;
		for (int k = 0; k < HISTORY_DEPTH; k++) begin
			seen |= hist_pat[k];
			if (hist_ok[k]) begin
				cnt++;
				acc += heading(hist_pat[k]);
			end
		end
		mean = (cnt != 0) ? acc / cnt : 0;
		r.left_speed = '0;
		r.right_speed = '0;
		if (pat != '0) begin
			gsum = int'(weight_p) + int'(weight_d) + int'(weight_i);
			sum = 0;
			if (gsum != 0) begin
				sum = (int'(weight_p) * p + int'(weight_d) * d + int'(weight_i) * mean) / gsum;
			end
			if (sum > SUM_LIMIT) sum = SUM_LIMIT;
			if (sum < -SUM_LIMIT) sum = -SUM_LIMIT;
			r.left_speed = SPEED_W'(BASE_SPEED + SPEED_STEP * sum);
			r.right_speed = SPEED_W'(BASE_SPEED - SPEED_STEP * sum);
		end
		r.line_seen = (seen != '0);
		r.prop_term = dir_t'(p);
		r.deriv_term = dir_t'(d);
		r.integ_term = dir_t'(mean);
		steer_expect_q.push_back(r);
	endfunction

	task automatic note_mismatch(string msg);
		$display("%0t: %s", $time, msg);
		err_count++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				take_reading(line_pattern);
				void'(pattern_q.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (pattern_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					in_valid <= 1'b1;
					line_pattern <= pattern_q[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		steer_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (steer_expect_q.size() == 0) begin
					note_mismatch("result word with nothing expected");
				end else begin
					want = steer_expect_q.pop_front();
					if (left_speed !== want.left_speed)
						note_mismatch($sformatf("left_speed got %0d expected %0d",
							left_speed, want.left_speed));
					if (right_speed !== want.right_speed)
						note_mismatch($sformatf("right_speed got %0d expected %0d",
							right_speed, want.right_speed));
					if (line_seen !== want.line_seen)
						note_mismatch($sformatf("line_seen got %0d expected %0d",
							line_seen, want.line_seen));
					if (prop_term !== want.prop_term)
						note_mismatch($sformatf("prop_term got %0d expected %0d",
							prop_term, want.prop_term));
					if (deriv_term !== want.deriv_term)
						note_mismatch($sformatf("deriv_term got %0d expected %0d",
							deriv_term, want.deriv_term));
					if (integ_term !== want.integ_term)
						note_mismatch($sformatf("integ_term got %0d expected %0d",
							integ_term, want.integ_term));
				end
			end
			out_stall <= long_hold || ($urandom_range(0, 99) < recv_idle);
		end
	end

	// long receiver hold-off so the block backs up
	initial begin
		wait (pressure_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (400) @(posedge clk);
		long_hold <= 1'b0;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_COMMIT_INTERVAL: commit_every = val;
			REG_GAIN_P:          weight_p = val;
			REG_GAIN_D:          weight_d = val;
			REG_GAIN_I:          weight_i = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (pattern_q.size() != 0 || steer_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic pattern_t pick_pattern();
		int w;
		int pos;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return pattern_t'($urandom);
			default: begin
				w = $urandom_range(1, 3);
				pos = $urandom_range(0, SENSOR_COUNT - w);
				return pattern_t'(((1 << w) - 1) << pos);
			end
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		if ($urandom_range(0, 4) == 0) begin
			return ($urandom_range(0, 1) != 0) ? 4'd15 : 4'd0;
		end
		return GAIN_W'($urandom_range(0, 15));
	endfunction

	initial begin
		pattern_t first_words [10];
		first_words = '{8'h18, 8'h3c, 8'h81, 8'h42, 8'hff,
			8'h24, 8'h99, 8'h66, 8'h7e, 8'h00};
		for (int k = 0; k < HISTORY_DEPTH; k++) begin
			hist_pat[k] = '0;
			hist_ok[k] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings straight out of reset
		foreach (first_words[k]) pattern_q.push_back(first_words[k]);
		settle();

		// every word commits, all gains at the top
		write_reg(REG_COMMIT_INTERVAL, 4'd1);
		write_reg(REG_GAIN_P, 4'd15);
		write_reg(REG_GAIN_D, 4'd15);
		write_reg(REG_GAIN_I, 4'd15);
		for (int b = 0; b < SENSOR_COUNT; b++) pattern_q.push_back(pattern_t'(1 << b));
		pattern_q.push_back(8'h55);
		pattern_q.push_back(8'haa);
		settle();

		// zero gain total, interval of zero
		write_reg(REG_COMMIT_INTERVAL, 4'd0);
		write_reg(REG_GAIN_P, 4'd0);
		write_reg(REG_GAIN_D, 4'd0);
		write_reg(REG_GAIN_I, 4'd0);
		pattern_q.push_back(8'h07);
		pattern_q.push_back(8'h00);
		settle();

		// interval lowered below the pending count
		write_reg(REG_COMMIT_INTERVAL, 4'd15);
		write_reg(REG_GAIN_P, 4'd8);
		repeat (4) pattern_q.push_back(pick_pattern());
		settle();
		write_reg(REG_COMMIT_INTERVAL, 4'd2);
		pattern_q.push_back(8'he0);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 3) begin
				send_idle = 23;
				recv_idle = 69;
			end else if (ph < 6) begin
				send_idle = 69;
				recv_idle = 23;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (ph == 6) begin
				write_reg(REG_COMMIT_INTERVAL, 4'd1);
			end else if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_COMMIT_INTERVAL, GAIN_W'($urandom_range(0, 15)));
			end else begin
				write_reg(REG_COMMIT_INTERVAL, GAIN_W'($urandom_range(1, 3)));
			end
			write_reg(REG_GAIN_P, pick_gain());
			write_reg(REG_GAIN_D, pick_gain());
			write_reg(REG_GAIN_I, pick_gain());
			if (ph == 6) pressure_go = 1'b1;
			repeat (65) pattern_q.push_back(pick_pattern());
			settle();
		end

		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
